// ===== hw/rtl/ps2mt_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet tracker.
package ps2mt_pkg;

  // Default pointer coordinate width.
  localparam int unsigned CoordBitsDef = 12;

  // Size registers and the configuration port.
  localparam int unsigned SizeBits   = 13;
  localparam int unsigned CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] RegScreenWidth  = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegScreenHeight = 2'd1;
  localparam logic [SizeBits-1:0] WidthReset  = 13'd640;
  localparam logic [SizeBits-1:0] HeightReset = 13'd480;

  // Widths of the packet bytes and of the per-axis movement.
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned MoveBits   = 9;
  localparam int unsigned DeltaBits  = 10;
  localparam int unsigned ButtonBits = 3;

  // Flag byte layout.
  localparam int unsigned FlagSyncBit  = 3;
  localparam int unsigned FlagXSignBit = 4;
  localparam int unsigned FlagYSignBit = 5;
  localparam logic [ByteBits-1:0] FlagOvfMask = 8'hC0;
  localparam logic [ByteBits-1:0] FlagBtnMask = 8'h07;

  // Position of the next byte within a packet.
  typedef enum logic [1:0] {
    PosFlag = 2'd0,
    PosDx   = 2'd1,
    PosDy   = 2'd2
  } pos_e;

  // One complete, accepted packet as handed to the pointer logic.
  typedef struct packed {
    logic                  valid;
    logic [MoveBits-1:0]   dx;
    logic [MoveBits-1:0]   dy;
    logic [ButtonBits-1:0] buttons;
  } move_t;

endpackage

// ===== hw/rtl/ps2mt_framer.sv =====
// Byte framing: locks onto flag bytes and assembles three-byte packets.
module ps2mt_framer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [ps2mt_pkg::ByteBits-1:0] data_byte_i,
  input  logic                          clear_i,
  output ps2mt_pkg::move_t              move_o
);
  import ps2mt_pkg::*;

  pos_e                pos_q, pos_d;
  logic [ByteBits-1:0] flag_q, flag_d;
  logic [ByteBits-1:0] dxb_q, dxb_d;

  // Position register, with the captured flag and dx bytes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosFlag;
      flag_q <= '0;
      dxb_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      flag_q <= flag_d;
      dxb_q  <= dxb_d;
    end
  end

  // Next position and the packet handed on when the third byte lands.
  always_comb begin
    pos_d          = pos_q;
    flag_d         = flag_q;
    dxb_d          = dxb_q;
    move_o.valid   = 1'b0;
    move_o.dx      = {flag_q[FlagXSignBit], dxb_q};
    move_o.dy      = {flag_q[FlagYSignBit], data_byte_i};
    move_o.buttons = ButtonBits'(flag_q & FlagBtnMask);
    if (clear_i) begin
      pos_d = PosFlag;
    end else if (accept_i) begin
      case (pos_q)
        PosFlag: begin
          // Only a byte with the sync bit set may open a packet.
          if (data_byte_i[FlagSyncBit]) begin
            flag_d = data_byte_i;
            pos_d  = PosDx;
          end
        end
        PosDx: begin
          dxb_d = data_byte_i;
          pos_d = PosDy;
        end
        PosDy: begin
          // A packet with either overflow bit set is consumed silently.
          pos_d        = PosFlag;
          move_o.valid = ((flag_q & FlagOvfMask) == '0);
        end
        default: begin
          pos_d = PosFlag;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ps2mt_axis.sv =====
// One pointer axis: size limit, centring on a size write, and clamped movement.
module ps2mt_axis #(
  parameter int unsigned                  COORD_BITS = ps2mt_pkg::CoordBitsDef,
  parameter logic [ps2mt_pkg::SizeBits-1:0] RESET_SIZE = ps2mt_pkg::WidthReset
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ps2mt_pkg::SizeBits-1:0]      cfg_size_i,
  input  logic                                move_i,
  input  logic signed [ps2mt_pkg::DeltaBits-1:0] delta_i,
  output logic [COORD_BITS-1:0]               pos_next_o
);
  import ps2mt_pkg::*;

  localparam int unsigned WideBits =
    (COORD_BITS + 1 > SizeBits) ? COORD_BITS + 1 : SizeBits;
  localparam logic [WideBits-1:0] Limit = WideBits'(2 ** COORD_BITS);

  // Largest coordinate for a given size: a zero size counts as one and
  // sizes beyond the coordinate range are cut back to it.
  function automatic logic [WideBits-1:0] max_of(logic [SizeBits-1:0] size);
    logic [WideBits-1:0] s;
    s = WideBits'(size);
    if (s == '0) s = WideBits'(1);
    if (s > Limit) s = Limit;
    return s - WideBits'(1);
  endfunction

  // Half the size, but never past the largest coordinate.
  function automatic logic [WideBits-1:0] centre_of(logic [SizeBits-1:0] size);
    logic [WideBits-1:0] c;
    logic [WideBits-1:0] m;
    c = WideBits'(size >> 1);
    m = max_of(size);
    return (c > m) ? m : c;
  endfunction

  localparam logic [COORD_BITS-1:0] RstMax    = COORD_BITS'(max_of(RESET_SIZE));
  localparam logic [COORD_BITS-1:0] RstCentre = COORD_BITS'(centre_of(RESET_SIZE));

  logic [COORD_BITS-1:0]        max_q, max_d;
  logic [COORD_BITS-1:0]        pos_q, pos_d;
  logic signed [COORD_BITS+1:0] sum;

  // Position plus signed movement, clamped to zero and to the axis limit.
  always_comb begin
    sum = $signed({2'b00, pos_q}) + (COORD_BITS + 2)'(delta_i);
    if (sum < 0) begin
      pos_next_o = '0;
    end else if (sum[COORD_BITS:0] > {1'b0, max_q}) begin
      pos_next_o = max_q;
    end else begin
      pos_next_o = sum[COORD_BITS-1:0];
    end
  end

  // A size write re-centres the axis; a packet moves it.
  always_comb begin
    max_d = max_q;
    pos_d = pos_q;
    if (cfg_we_i) begin
      max_d = COORD_BITS'(max_of(cfg_size_i));
      pos_d = COORD_BITS'(centre_of(cfg_size_i));
    end else if (move_i) begin
      pos_d = pos_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= RstMax;
      pos_q <= RstCentre;
    end else begin
      max_q <= max_d;
      pos_q <= pos_d;
    end
  end

endmodule

// ===== hw/rtl/ps2_mouse_packet_tracker_top.sv =====
// Top level of the PS/2 mouse packet tracker.
//
// Takes one mouse byte per beat and returns the pointer position and buttons
// once per good three-byte packet. A new byte can be accepted on every clock
// while the input is not stalled; the result appears in the output
// register on the edge after the third byte and waits there while stalled,
// which stalls the input only if the result has not yet been taken. Bytes
// before a flag byte (bit 3 set) are skipped, and packets with an overflow
// bit set give no result. Writing screen_width or screen_height re-centres
// that axis and restarts packet framing; write only while the block is idle.
module ps2_mouse_packet_tracker_top #(
  parameter int unsigned COORD_BITS = ps2mt_pkg::CoordBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ps2mt_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [ps2mt_pkg::SizeBits-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ps2mt_pkg::ByteBits-1:0]       data_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [COORD_BITS-1:0]                pointer_x_o,
  output logic [COORD_BITS-1:0]                pointer_y_o,
  output logic [ps2mt_pkg::ButtonBits-1:0]     button_bits_o
);
  import ps2mt_pkg::*;

  logic                          in_acc;
  logic                          cfg_x, cfg_y;
  move_t                         mv;
  logic signed [DeltaBits-1:0]   delta_x, delta_y;
  logic [COORD_BITS-1:0]         pos_x_next, pos_y_next;
  logic                          out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0]         px_q, py_q;
  logic [ButtonBits-1:0]         btn_q;

  // Handshake: the input waits only while a result is held up downstream.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Size register decode.
  assign cfg_x = cfg_we_i && (cfg_index_i == RegScreenWidth);
  assign cfg_y = cfg_we_i && (cfg_index_i == RegScreenHeight);

  ps2mt_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .data_byte_i (data_byte_i),
    .clear_i     (cfg_x | cfg_y),
    .move_o      (mv)
  );

  // X follows dx; Y runs the other way, since rows grow downward.
  assign delta_x = DeltaBits'($signed(mv.dx));
  assign delta_y = -(DeltaBits'($signed(mv.dy)));

  ps2mt_axis #(
    .COORD_BITS (COORD_BITS),
    .RESET_SIZE (WidthReset)
  ) u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_x),
    .cfg_size_i (cfg_data_i),
    .move_i     (mv.valid),
    .delta_i    (delta_x),
    .pos_next_o (pos_x_next)
  );

  ps2mt_axis #(
    .COORD_BITS (COORD_BITS),
    .RESET_SIZE (HeightReset)
  ) u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_y),
    .cfg_size_i (cfg_data_i),
    .move_i     (mv.valid),
    .delta_i    (delta_y),
    .pos_next_o (pos_y_next)
  );

  // Result register: loaded by a good packet, emptied when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (mv.valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv.valid) begin
      px_q  <= pos_x_next;
      py_q  <= pos_y_next;
      btn_q <= mv.buttons;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pointer_x_o   = px_q;
  assign pointer_y_o   = py_q;
  assign button_bits_o = btn_q;

  // A packet completes only on a byte that was actually taken.
  a_move_needs_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni) mv.valid |-> in_acc
  ) else $error("packet completed without an accepted byte");

  // A completed packet lands in the result register on the next edge.
  a_result_loaded : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    mv.valid |=> (out_valid_o && pointer_x_o == $past(pos_x_next) &&
                  pointer_y_o == $past(pos_y_next))
  ) else $error("result register not loaded from the finished packet");

  // A new result never appears without a byte accepted the cycle before.
  a_result_from_byte : assert property (
    @(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_o) |-> $past(in_acc)
  ) else $error("result appeared without an accepted byte");

endmodule
